// ===== rtl/srtf_pkg.sv =====
// Shared types, codes and widths for the SRTF scheduler.
package srtf_pkg;

    localparam int ID_W     = 8;
    localparam int BURST_W  = 16;
    localparam int OUT_TW   = 24;
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = 1;
    localparam int Q_CNT_W  = 2;

    // Item kinds on the command port
    localparam logic KIND_ARRIVE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // Operation codes carried through the queue
    localparam logic [1:0] OP_ARRIVE = 2'd0;
    localparam logic [1:0] OP_REJECT = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    typedef struct packed {
        logic               kind;
        logic [ID_W-1:0]    job_id;
        logic [BURST_W-1:0] burst_len;
    } in_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [ID_W-1:0]    job_id;
        logic [BURST_W-1:0] burst_len;
    } word_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              ran;
        logic [ID_W-1:0]   run_id;
        logic [OUT_TW-1:0] slot_start;
        logic              finished;
        logic [OUT_TW-1:0] finish_time;
        logic [OUT_TW-1:0] turnaround;
        logic [OUT_TW-1:0] waiting;
    } result_t;

endpackage

// ===== rtl/srtf_front.sv =====
// Front end: accepts command words, classifies them and hands them to the queue.
module srtf_front
    import srtf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  in_t   cmd,
    input  logic  q_full,
    output logic  busy,
    output logic  push,
    output word_t push_word
);

    logic  vld_reg;
    word_t word_reg;
    word_t word_next;
    logic  accept;

    // Stall the port only while a held word cannot enter the queue
    assign busy      = vld_reg && q_full;
    assign push      = vld_reg && !q_full;
    assign accept    = start && !busy;
    assign push_word = word_reg;

    // Classify the incoming word
    always_comb
    begin
        word_next.job_id    = cmd.job_id;
        word_next.burst_len = cmd.burst_len;
        if (cmd.kind == KIND_TICK)
        begin
            word_next.op = OP_TICK;
        end
        else if (cmd.burst_len == '0)
        begin
            word_next.op = OP_REJECT;
        end
        else
        begin
            word_next.op = OP_ARRIVE;
        end
    end

    // Hold the staged word until the queue takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            vld_reg <= 1'b1;
        end
        else if (push)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// ===== rtl/srtf_queue.sv =====
// Two-entry queue between the front end and the scheduling engine.
module srtf_queue
    import srtf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  word_t push_word,
    input  logic  pop,
    output logic  full,
    output logic  empty,
    output word_t head
);

    word_t              q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = q_mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ===== rtl/srtf_back.sv =====
// Scheduling engine: slot table, free-slot search, min-remaining scan and reporting.
module srtf_back
    import srtf_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int TIME_BITS = 24
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  word_t   q_head,
    output logic    pop,
    output logic    done,
    output result_t result
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int WB = (TIME_BITS > OUT_TW) ? TIME_BITS : OUT_TW;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FIND   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_REPORT = 3'd4;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        cnt_next;
    word_t                cur_reg;
    logic [NUM_SLOTS-1:0] slot_valid_reg;
    logic [TIME_BITS-1:0] now_reg;

    // Slot table memories
    logic [ID_W-1:0]      mem_id    [NUM_SLOTS];
    logic [TIME_BITS-1:0] mem_arr   [NUM_SLOTS];
    logic [BURST_W-1:0]   mem_burst [NUM_SLOTS];
    logic [BURST_W-1:0]   mem_rem   [NUM_SLOTS];

    // Scan read stage
    logic [ID_W-1:0]      rd_id_reg;
    logic [TIME_BITS-1:0] rd_arr_reg;
    logic [BURST_W-1:0]   rd_burst_reg;
    logic [BURST_W-1:0]   rd_rem_reg;
    logic [IW-1:0]        rd_idx_reg;
    logic                 rd_valid_reg;
    logic                 cmp_go_reg;

    // Best candidate so far
    logic                 best_found_reg;
    logic [IW-1:0]        best_idx_reg;
    logic [ID_W-1:0]      best_id_reg;
    logic [TIME_BITS-1:0] best_arr_reg;
    logic [BURST_W-1:0]   best_burst_reg;
    logic [BURST_W-1:0]   best_rem_reg;

    // Update stage results
    logic                 ran_reg;
    logic                 fin_reg;
    logic [ID_W-1:0]      run_id_reg;
    logic [TIME_BITS-1:0] start_reg;
    logic [TIME_BITS-1:0] finish_reg;
    logic [TIME_BITS-1:0] tat_reg;

    logic                 done_reg;
    result_t              res_reg;
    result_t              res_next;

    logic [IW-1:0]        idx;
    logic                 find_free;
    logic                 find_full;
    logic                 issue;
    logic                 less;
    logic                 take;
    logic                 scan_end;
    logic                 upd;
    logic [BURST_W-1:0]   rem_dec;
    logic                 done_job;
    logic [TIME_BITS-1:0] now_inc;
    logic [TIME_BITS-1:0] tat_next;
    logic                 emit_zero;
    logic                 emit;
    logic                 wr_rem_en;
    logic [IW-1:0]        wr_rem_addr;
    logic [BURST_W-1:0]   wr_rem_data;
    logic [WB-1:0]        start_w;
    logic [WB-1:0]        finish_w;
    logic [WB-1:0]        tat_w;
    logic [WB-1:0]        burst_w;
    logic [WB-1:0]        wait_w;

    assign idx       = cnt_reg[IW-1:0];
    assign pop       = (state_reg == S_IDLE) && !q_empty;
    assign emit_zero = pop && (q_head.op == OP_REJECT);
    assign find_free = (state_reg == S_FIND) && !slot_valid_reg[idx];
    assign find_full = (state_reg == S_FIND) && slot_valid_reg[idx]
                       && (cnt_reg == CW'(NUM_SLOTS - 1));
    assign issue     = (state_reg == S_SCAN) && (cnt_reg != CW'(NUM_SLOTS));
    assign scan_end  = (state_reg == S_SCAN) && cmp_go_reg
                       && (cnt_reg == CW'(NUM_SLOTS));
    assign upd       = (state_reg == S_UPDATE);
    assign emit      = emit_zero || find_free || find_full || (state_reg == S_REPORT);

    // Order: less remaining, then earlier arrival, then lower id
    assign less = (rd_rem_reg < best_rem_reg)
                  || ((rd_rem_reg == best_rem_reg) && (rd_arr_reg < best_arr_reg))
                  || ((rd_rem_reg == best_rem_reg) && (rd_arr_reg == best_arr_reg)
                      && (rd_id_reg < best_id_reg));
    assign take = cmp_go_reg && rd_valid_reg && (!best_found_reg || less);

    // Update arithmetic
    assign rem_dec  = best_rem_reg - 1'b1;
    assign done_job = best_found_reg && (rem_dec == '0);
    assign now_inc  = (now_reg == TIME_MAX) ? now_reg : now_reg + 1'b1;
    assign tat_next = now_inc - best_arr_reg;

    // Remaining-time write port
    assign wr_rem_en   = find_free || (upd && best_found_reg);
    assign wr_rem_addr = find_free ? idx : best_idx_reg;
    assign wr_rem_data = find_free ? cur_reg.burst_len : rem_dec;

    // Report arithmetic
    assign start_w  = WB'(start_reg);
    assign finish_w = WB'(finish_reg);
    assign tat_w    = WB'(tat_reg);
    assign burst_w  = WB'(best_burst_reg);
    assign wait_w   = (tat_w > burst_w) ? (tat_w - burst_w) : '0;

    // Sequence the engine
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    cnt_next = '0;
                    case (q_head.op)
                        OP_ARRIVE: state_next = S_FIND;
                        OP_TICK:   state_next = S_SCAN;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_FIND:
            begin
                if (find_free || find_full)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (scan_end)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: state_next = S_REPORT;
            S_REPORT: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Build the result word
    always_comb
    begin
        res_next = '0;
        if (emit_zero)
        begin
            res_next.status = ST_ZERO;
        end
        else if (find_full)
        begin
            res_next.status = ST_FULL;
        end
        else if (state_reg == S_REPORT)
        begin
            res_next.status     = ST_OK;
            res_next.slot_start = start_w[OUT_TW-1:0];
            res_next.ran        = ran_reg;
            if (ran_reg)
            begin
                res_next.run_id = run_id_reg;
            end
            if (fin_reg)
            begin
                res_next.finished    = 1'b1;
                res_next.finish_time = finish_w[OUT_TW-1:0];
                res_next.turnaround  = tat_w[OUT_TW-1:0];
                res_next.waiting     = wait_w[OUT_TW-1:0];
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            slot_valid_reg <= '0;
            now_reg        <= '0;
            cmp_go_reg     <= 1'b0;
            best_found_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            cmp_go_reg <= issue;
            done_reg   <= emit;
            if (find_free)
            begin
                slot_valid_reg[idx] <= 1'b1;
            end
            if (upd && done_job)
            begin
                slot_valid_reg[best_idx_reg] <= 1'b0;
            end
            if (upd)
            begin
                now_reg <= now_inc;
            end
            if (pop && (q_head.op == OP_TICK))
            begin
                best_found_reg <= 1'b0;
            end
            else if (take)
            begin
                best_found_reg <= 1'b1;
            end
        end
    end

    // Slot table write and scan read
    always_ff @(posedge clk)
    begin
        if (find_free)
        begin
            mem_id[idx]    <= cur_reg.job_id;
            mem_arr[idx]   <= now_reg;
            mem_burst[idx] <= cur_reg.burst_len;
        end
        if (wr_rem_en)
        begin
            mem_rem[wr_rem_addr] <= wr_rem_data;
        end
        if (issue)
        begin
            rd_id_reg    <= mem_id[idx];
            rd_arr_reg   <= mem_arr[idx];
            rd_burst_reg <= mem_burst[idx];
            rd_rem_reg   <= mem_rem[idx];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_head;
        end
        if (issue)
        begin
            rd_idx_reg   <= idx;
            rd_valid_reg <= slot_valid_reg[idx];
        end
        if (take)
        begin
            best_idx_reg   <= rd_idx_reg;
            best_id_reg    <= rd_id_reg;
            best_arr_reg   <= rd_arr_reg;
            best_burst_reg <= rd_burst_reg;
            best_rem_reg   <= rd_rem_reg;
        end
        if (upd)
        begin
            ran_reg    <= best_found_reg;
            fin_reg    <= done_job;
            run_id_reg <= best_id_reg;
            start_reg  <= now_reg;
            finish_reg <= now_inc;
            tat_reg    <= tat_next;
        end
        if (emit)
        begin
            res_reg <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== rtl/srtf_scheduler.sv =====
// Top level of the shortest-remaining-time-first scheduler.
//
// Command channel: drive start with a word on cmd; the word is taken at a
// rising edge where start is high and busy is low. kind 0 is a job arrival
// (job_id, burst_len), kind 1 is one time tick.
// Result channel: every word gives exactly one result on result, shown for
// a single cycle while done is high. The receiver cannot stall; it must
// take each result in the cycle it appears.
// A front stage and a two-entry queue take words while the engine works.
// Engine steps per word, with N = NUM_SLOTS slots:
//   zero-burst arrival: rejected as it is popped from the queue
//   arrival: up to N slots checked, one slot per cycle, for a free entry
//   tick: a scan that reads one table entry per cycle from the slot
//   memory, then an update and a report step.
// The engine takes a new word only once it is through with the last one;
// busy rises once queue and front stage are both full.
// Reset empties the table, clears time to zero and drops queued words.
module srtf_scheduler
    import srtf_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int TIME_BITS = 24
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  in_t     cmd,
    output logic    busy,
    output logic    done,
    output result_t result
);

    logic  q_push;
    word_t q_push_word;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    word_t q_head;

    srtf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .q_full    (q_full),
        .busy      (busy),
        .push      (q_push),
        .push_word (q_push_word)
    );

    srtf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_push_word),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    srtf_back #(
        .NUM_SLOTS (NUM_SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .pop     (q_pop),
        .done    (done),
        .result  (result)
    );

    // A rejected or dropped arrival never reports a run
    a_status_no_run: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status != ST_OK) |-> !result.ran)
        else $error("non-ok status with ran set");

    // Completion only for a job that ran
    a_finish_ran: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.finished |-> result.ran)
        else $error("finished without ran");

    // Busy rises only after a word was accepted
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted word");

    // Engine pops only a non-empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

endmodule
